// File: hdl/assert_macros.svh
// Assertion macros shared by the pose composition RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked at every rising edge, switched off while reset is high
`define RPC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge, reset included
`define RPC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPC_ASSERT(label, clk, rst, prop, msg)
`define RPC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: hdl/rpc_pkg.sv
// Types, register indices and rounding helpers for the pose composition block.
`default_nettype none
package rpc_pkg;

  // Field types
  typedef logic signed [31:0] pos_t;    // Q23.8 translation
  typedef logic signed [15:0] qc_t;     // Q1.14 quaternion component
  typedef logic signed [31:0] qprod_t;  // Q2.28 component product
  typedef logic signed [33:0] mexp_t;   // matrix entry before rounding, Q.28
  typedef logic signed [25:0] mat_t;    // matrix entry, Q.20
  typedef logic signed [57:0] pprod_t;  // matrix entry times coordinate
  typedef logic signed [34:0] qsum_t;   // sum of four Q2.28 products
  typedef logic signed [39:0] rot_t;    // rotated coordinate, Q31.8
  typedef logic [2:0]         cfg_idx_t;

  // Register indices on the configuration port
  localparam cfg_idx_t REG_POS_X  = 3'd0;
  localparam cfg_idx_t REG_POS_Y  = 3'd1;
  localparam cfg_idx_t REG_POS_Z  = 3'd2;
  localparam cfg_idx_t REG_QUAT_X = 3'd3;
  localparam cfg_idx_t REG_QUAT_Y = 3'd4;
  localparam cfg_idx_t REG_QUAT_Z = 3'd5;
  localparam cfg_idx_t REG_QUAT_W = 3'd6;

  localparam qc_t   QUAT_ONE     = 16'sd16384;
  localparam mexp_t MAT_ONE      = 34'sd268435456;   // 1.0 in Q.28
  localparam int    PIPE_STAGES  = 5;

  // Matrix entry: 2*(a +- b), minus 1.0 on the diagonal, rounded half up to Q.20
  function automatic mat_t mat_entry(input qprod_t a, input qprod_t b,
                                     input logic sub, input logic diag);
    mexp_t s;
    mexp_t e;
    s = sub ? (34'(a) - 34'(b)) : (34'(a) + 34'(b));
    e = (s <<< 1) - (diag ? MAT_ONE : 34'sd0);
    e = e + 34'sd128;
    return e[33:8];
  endfunction

  // Round half up to Q1.14 and saturate to plus or minus 1.0
  function automatic qc_t quat_round(input qsum_t s);
    qsum_t               r;
    logic signed [20:0]  sh;
    r  = s + 35'sd8192;
    sh = r[34:14];
    if (sh > 21'sd16384) begin
      return QUAT_ONE;
    end else if (sh < -21'sd16384) begin
      return -QUAT_ONE;
    end else begin
      return sh[15:0];
    end
  endfunction

  // Add the reference offset and saturate to the signed 32-bit range
  function automatic pos_t pos_sat(input rot_t r, input pos_t t);
    logic signed [40:0] s;
    s = 41'(r) + 41'(t);
    if (s > 41'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -41'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return s[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: hdl/rigid_pose_compose_top.sv
// Pose composition: reference pose applied to a stream of object poses, five-stage pipeline.
//
// Each input beat is a pose (Q23.8 translation, Q1.14 quaternion); each output beat is
// that pose composed with the reference pose in the configuration registers: quaternion
// r*q, translation R(r)*p + t. One pose is taken every clock unless the output stalls,
// and the stages are input register, quaternion products, nine 26x32 matrix-by-coordinate
// multipliers, the three-term row sums, and the offset add with saturation. The rotation
// matrix is rebuilt from the registers by a two-stage side pipeline, so a register write
// counts for every pose accepted on a later clock. An output stall holds the whole
// pipeline; input ready is high whenever the last stage is empty or being taken, and low
// during reset. Register writes are taken on any cycle out of reset.
`default_nettype none
`include "assert_macros.svh"
module rigid_pose_compose_top (
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration write channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire rpc_pkg::cfg_idx_t   cfg_index,
  input  wire logic [31:0]         cfg_data,
  // input pose channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rpc_pkg::pos_t       in_pos_x,
  input  wire rpc_pkg::pos_t       in_pos_y,
  input  wire rpc_pkg::pos_t       in_pos_z,
  input  wire rpc_pkg::qc_t        in_quat_x,
  input  wire rpc_pkg::qc_t        in_quat_y,
  input  wire rpc_pkg::qc_t        in_quat_z,
  input  wire rpc_pkg::qc_t        in_quat_w,
  // output pose channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rpc_pkg::pos_t            out_pos_x,
  output rpc_pkg::pos_t            out_pos_y,
  output rpc_pkg::pos_t            out_pos_z,
  output rpc_pkg::qc_t             out_quat_x,
  output rpc_pkg::qc_t             out_quat_y,
  output rpc_pkg::qc_t             out_quat_z,
  output rpc_pkg::qc_t             out_quat_w
);

  // Reference pose registers; quaternion order is x, y, z, w
  rpc_pkg::pos_t   ref_pos [3];
  rpc_pkg::qc_t    ref_quat [4];

  // Side pipeline for the rotation matrix
  rpc_pkg::qprod_t mp_xx, mp_yy, mp_zz, mp_ww, mp_xy, mp_xz, mp_yz, mp_wx, mp_wy, mp_wz;
  rpc_pkg::mat_t   mat [9];

  // Main pipeline
  logic [rpc_pkg::PIPE_STAGES-1:0] vld;
  logic                            adv;

  rpc_pkg::pos_t   s1_pos [3];
  rpc_pkg::qc_t    s1_quat [4];
  rpc_pkg::pos_t   s2_pos [3];
  rpc_pkg::qprod_t qp [16];
  rpc_pkg::qprod_t qp_next [16];
  rpc_pkg::pprod_t s3_pp [9];
  rpc_pkg::qc_t    s3_quat [4];
  rpc_pkg::qc_t    s3_quat_next [4];
  rpc_pkg::rot_t   s4_rot [3];
  rpc_pkg::qc_t    s4_quat [4];
  rpc_pkg::pos_t   s5_pos [3];
  rpc_pkg::qc_t    s5_quat [4];

  // Handshakes
  assign adv       = !vld[rpc_pkg::PIPE_STAGES-1] || out_ready;
  assign in_ready  = adv && !rst;
  assign cfg_ready = !rst;
  assign out_valid = vld[rpc_pkg::PIPE_STAGES-1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_pos[0]  <= '0;
      ref_pos[1]  <= '0;
      ref_pos[2]  <= '0;
      ref_quat[0] <= '0;
      ref_quat[1] <= '0;
      ref_quat[2] <= '0;
      ref_quat[3] <= rpc_pkg::QUAT_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rpc_pkg::REG_POS_X:  ref_pos[0]  <= cfg_data;
        rpc_pkg::REG_POS_Y:  ref_pos[1]  <= cfg_data;
        rpc_pkg::REG_POS_Z:  ref_pos[2]  <= cfg_data;
        rpc_pkg::REG_QUAT_X: ref_quat[0] <= cfg_data[15:0];
        rpc_pkg::REG_QUAT_Y: ref_quat[1] <= cfg_data[15:0];
        rpc_pkg::REG_QUAT_Z: ref_quat[2] <= cfg_data[15:0];
        rpc_pkg::REG_QUAT_W: ref_quat[3] <= cfg_data[15:0];
        default: ;  // index beyond the register list: ignored
      endcase
    end
  end

  // Rotation matrix from the reference quaternion, free running
  always_ff @(posedge clk) begin
    mp_xx <= ref_quat[0] * ref_quat[0];
    mp_yy <= ref_quat[1] * ref_quat[1];
    mp_zz <= ref_quat[2] * ref_quat[2];
    mp_ww <= ref_quat[3] * ref_quat[3];
    mp_xy <= ref_quat[0] * ref_quat[1];
    mp_xz <= ref_quat[0] * ref_quat[2];
    mp_yz <= ref_quat[1] * ref_quat[2];
    mp_wx <= ref_quat[3] * ref_quat[0];
    mp_wy <= ref_quat[3] * ref_quat[1];
    mp_wz <= ref_quat[3] * ref_quat[2];
    mat[0] <= rpc_pkg::mat_entry(mp_xx, mp_ww, 1'b0, 1'b1);
    mat[1] <= rpc_pkg::mat_entry(mp_xy, mp_wz, 1'b1, 1'b0);
    mat[2] <= rpc_pkg::mat_entry(mp_wy, mp_xz, 1'b0, 1'b0);
    mat[3] <= rpc_pkg::mat_entry(mp_xy, mp_wz, 1'b0, 1'b0);
    mat[4] <= rpc_pkg::mat_entry(mp_yy, mp_ww, 1'b0, 1'b1);
    mat[5] <= rpc_pkg::mat_entry(mp_yz, mp_wx, 1'b1, 1'b0);
    mat[6] <= rpc_pkg::mat_entry(mp_xz, mp_wy, 1'b1, 1'b0);
    mat[7] <= rpc_pkg::mat_entry(mp_wx, mp_yz, 1'b0, 1'b0);
    mat[8] <= rpc_pkg::mat_entry(mp_zz, mp_ww, 1'b0, 1'b1);
  end

  // Hamilton product terms, grouped four per output component
  always_comb begin
    // x: rw*qx + rx*qw + ry*qz - rz*qy
    qp_next[0]  = s1_quat[0] * ref_quat[3];
    qp_next[1]  = s1_quat[3] * ref_quat[0];
    qp_next[2]  = s1_quat[2] * ref_quat[1];
    qp_next[3]  = s1_quat[1] * ref_quat[2];
    // y: rw*qy - rx*qz + ry*qw + rz*qx
    qp_next[4]  = s1_quat[1] * ref_quat[3];
    qp_next[5]  = s1_quat[2] * ref_quat[0];
    qp_next[6]  = s1_quat[3] * ref_quat[1];
    qp_next[7]  = s1_quat[0] * ref_quat[2];
    // z: rw*qz + rx*qy - ry*qx + rz*qw
    qp_next[8]  = s1_quat[2] * ref_quat[3];
    qp_next[9]  = s1_quat[1] * ref_quat[0];
    qp_next[10] = s1_quat[0] * ref_quat[1];
    qp_next[11] = s1_quat[3] * ref_quat[2];
    // w: rw*qw - rx*qx - ry*qy - rz*qz
    qp_next[12] = s1_quat[3] * ref_quat[3];
    qp_next[13] = s1_quat[0] * ref_quat[0];
    qp_next[14] = s1_quat[1] * ref_quat[1];
    qp_next[15] = s1_quat[2] * ref_quat[2];
  end

  // Quaternion sums with rounding and saturation
  always_comb begin
    s3_quat_next[0] = rpc_pkg::quat_round(35'(qp[0]) + 35'(qp[1]) + 35'(qp[2]) - 35'(qp[3]));
    s3_quat_next[1] = rpc_pkg::quat_round(35'(qp[4]) - 35'(qp[5]) + 35'(qp[6]) + 35'(qp[7]));
    s3_quat_next[2] = rpc_pkg::quat_round(35'(qp[8]) + 35'(qp[9]) - 35'(qp[10])
                                          + 35'(qp[11]));
    s3_quat_next[3] = rpc_pkg::quat_round(35'(qp[12]) - 35'(qp[13]) - 35'(qp[14])
                                          - 35'(qp[15]));
  end

  // Valid bits travel with the beats; everything moves on adv
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[rpc_pkg::PIPE_STAGES-2:0], in_valid};
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: accepted beat
      s1_pos[0]  <= in_pos_x;
      s1_pos[1]  <= in_pos_y;
      s1_pos[2]  <= in_pos_z;
      s1_quat[0] <= in_quat_x;
      s1_quat[1] <= in_quat_y;
      s1_quat[2] <= in_quat_z;
      s1_quat[3] <= in_quat_w;
      // stage 2: quaternion products
      qp <= qp_next;
      s2_pos <= s1_pos;
      // stage 3: matrix times coordinate, quaternion result
      for (int i = 0; i < 9; i++) begin
        s3_pp[i] <= 58'(mat[i]) * 58'(s2_pos[i % 3]);
      end
      s3_quat <= s3_quat_next;
      // stage 4: row sums rounded half up to Q23.8
      for (int i = 0; i < 3; i++) begin
        s4_rot[i] <= rpc_pkg::rot_t'((60'(s3_pp[3*i]) + 60'(s3_pp[3*i+1])
                                     + 60'(s3_pp[3*i+2]) + 60'sd524288) >>> 20);
      end
      s4_quat <= s3_quat;
      // stage 5: reference offset and saturation
      for (int i = 0; i < 3; i++) begin
        s5_pos[i] <= rpc_pkg::pos_sat(s4_rot[i], ref_pos[i]);
      end
      s5_quat <= s4_quat;
    end
  end

  // Output beat
  assign out_pos_x  = s5_pos[0];
  assign out_pos_y  = s5_pos[1];
  assign out_pos_z  = s5_pos[2];
  assign out_quat_x = s5_quat[0];
  assign out_quat_y = s5_quat[1];
  assign out_quat_z = s5_quat[2];
  assign out_quat_w = s5_quat[3];

  // Checks
  `RPC_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid, "output valid after reset")
  `RPC_ASSERT(a_stall_freezes, clk, rst, (out_valid && !out_ready) |=> $stable(vld),
              "pipeline moved during an output stall")
  `RPC_ASSERT(a_accept_enters, clk, rst, (in_valid && in_ready) |=> vld[0],
              "accepted beat missing from first stage")
  `RPC_ASSERT(a_quat_range, clk, rst,
              out_valid |-> (out_quat_x <= 16'sd16384 && out_quat_x >= -16'sd16384
                             && out_quat_y <= 16'sd16384 && out_quat_y >= -16'sd16384
                             && out_quat_z <= 16'sd16384 && out_quat_z >= -16'sd16384
                             && out_quat_w <= 16'sd16384 && out_quat_w >= -16'sd16384),
              "output quaternion component beyond 1.0")

endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the reference pose composition block.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  typedef rpc_pkg::pos_t     pos_t;
  typedef rpc_pkg::qc_t      qc_t;
  typedef rpc_pkg::cfg_idx_t cfg_idx_t;

  typedef struct {
    pos_t px;
    pos_t py;
    pos_t pz;
    qc_t  qx;
    qc_t  qy;
    qc_t  qz;
    qc_t  qw;
  } pose_t;

  localparam cfg_idx_t REG_UNUSED = 3'd7;
  localparam longint   POS_HI     = 64'sd2147483647;
  localparam longint   POS_LO     = -64'sd2147483648;
  localparam pos_t     P_MAX      = 32'sh7fffffff;
  localparam pos_t     P_MIN      = 32'sh80000000;
  localparam qc_t      Q_ONE      = rpc_pkg::QUAT_ONE;
  localparam qc_t      Q_MONE     = -rpc_pkg::QUAT_ONE;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_t    cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  pos_t        in_pos_x, in_pos_y, in_pos_z;
  qc_t         in_quat_x, in_quat_y, in_quat_z, in_quat_w;
  logic        out_valid;
  logic        out_ready;
  pos_t        out_pos_x, out_pos_y, out_pos_z;
  qc_t         out_quat_x, out_quat_y, out_quat_z, out_quat_w;

  // head pose as the predictor sees it
  pos_t head_px, head_py, head_pz;
  qc_t  head_qx, head_qy, head_qz, head_qw;

  pose_t pose_q[$];      // poses waiting to be sent
  pose_t composed_q[$];  // composed poses waiting to come out
  pose_t cur_pose;
  pose_t got;
  pose_t want;
  logic  in_taken;

  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_left;
  int stall_cyc;
  int poses_sent;
  int results_seen;
  int mismatches;
  int cfg_writes;
  int settings;

  rigid_pose_compose_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_pos_z   (in_pos_z),
    .in_quat_x  (in_quat_x),
    .in_quat_y  (in_quat_y),
    .in_quat_z  (in_quat_z),
    .in_quat_w  (in_quat_w),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .out_pos_z  (out_pos_z),
    .out_quat_x (out_quat_x),
    .out_quat_y (out_quat_y),
    .out_quat_z (out_quat_z),
    .out_quat_w (out_quat_w)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // round half up, then floor shift by n
  function automatic longint round_shift(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pose_t compose_pose(input pose_t p);
    longint rx, ry, rz, rw, qx, qy, qz, qw;
    longint px, py, pz, one, qlim;
    longint m [9];
    pose_t  r;
    rx = head_qx; ry = head_qy; rz = head_qz; rw = head_qw;
    qx = p.qx; qy = p.qy; qz = p.qz; qw = p.qw;
    px = p.px; py = p.py; pz = p.pz;
    one  = longint'(1) <<< 28;
    qlim = longint'(rpc_pkg::QUAT_ONE);
    // rotation matrix of the head quaternion, Q.20
    m[0] = round_shift(2 * (rx * rx + rw * rw) - one, 8);
    m[1] = round_shift(2 * (rx * ry - rw * rz), 8);
    m[2] = round_shift(2 * (rw * ry + rx * rz), 8);
    m[3] = round_shift(2 * (rx * ry + rw * rz), 8);
    m[4] = round_shift(2 * (ry * ry + rw * rw) - one, 8);
    m[5] = round_shift(2 * (ry * rz - rw * rx), 8);
    m[6] = round_shift(2 * (rx * rz - rw * ry), 8);
    m[7] = round_shift(2 * (rw * rx + ry * rz), 8);
    m[8] = round_shift(2 * (rz * rz + rw * rw) - one, 8);
    // rotated translation plus head offset, saturated
    r.px = pos_t'(clip(round_shift(m[0] * px + m[1] * py + m[2] * pz, 20) + head_px,
                       POS_LO, POS_HI));
    r.py = pos_t'(clip(round_shift(m[3] * px + m[4] * py + m[5] * pz, 20) + head_py,
                       POS_LO, POS_HI));
    r.pz = pos_t'(clip(round_shift(m[6] * px + m[7] * py + m[8] * pz, 20) + head_pz,
                       POS_LO, POS_HI));
    // Hamilton product head * object
    r.qx = qc_t'(clip(round_shift(rw * qx + rx * qw + ry * qz - rz * qy, 14), -qlim, qlim));
    r.qy = qc_t'(clip(round_shift(rw * qy - rx * qz + ry * qw + rz * qx, 14), -qlim, qlim));
    r.qz = qc_t'(clip(round_shift(rw * qz + rx * qy - ry * qx + rz * qw, 14), -qlim, qlim));
    r.qw = qc_t'(clip(round_shift(rw * qw - rx * qx - ry * qy - rz * qz, 14), -qlim, qlim));
    return r;
  endfunction

  function automatic string pose_str(input pose_t p);
    return $sformatf("pos=(%0d,%0d,%0d) quat=(%0d,%0d,%0d,%0d)",
                     p.px, p.py, p.pz, p.qx, p.qy, p.qz, p.qw);
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  task automatic add_pose(input pos_t px, input pos_t py, input pos_t pz,
                          input qc_t qx, input qc_t qy, input qc_t qz, input qc_t qw);
    pose_t p;
    p.px = px; p.py = py; p.pz = pz;
    p.qx = qx; p.qy = qy; p.qz = qz; p.qw = qw;
    pose_q.push_back(p);
  endtask

  function automatic pos_t rand_pos();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 4))
          0: return P_MAX;
          1: return P_MIN;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2, 3: return pos_t'($urandom_range(0, 131072)) - 32'sd65536;
      default: return pos_t'($urandom);
    endcase
  endfunction

  function automatic qc_t rand_qc();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_ONE;
          1: return Q_MONE;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      // outside the nominal range, used as given
      1: return qc_t'($urandom);
      default: return qc_t'($urandom_range(0, 32768)) - Q_ONE;
    endcase
  endfunction

  // one register write; predictor copy follows on acceptance
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rpc_pkg::REG_POS_X:  head_px = data;
      rpc_pkg::REG_POS_Y:  head_py = data;
      rpc_pkg::REG_POS_Z:  head_pz = data;
      rpc_pkg::REG_QUAT_X: head_qx = data[15:0];
      rpc_pkg::REG_QUAT_Y: head_qy = data[15:0];
      rpc_pkg::REG_QUAT_Z: head_qz = data[15:0];
      rpc_pkg::REG_QUAT_W: head_qw = data[15:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // whole head pose; upper bits of the quaternion words carry junk
  task automatic load_head(input pos_t tx, input pos_t ty, input pos_t tz,
                           input qc_t x, input qc_t y, input qc_t z, input qc_t w);
    write_reg(rpc_pkg::REG_POS_X, tx);
    write_reg(rpc_pkg::REG_POS_Y, ty);
    write_reg(rpc_pkg::REG_POS_Z, tz);
    write_reg(rpc_pkg::REG_QUAT_X, {16'($urandom), x});
    write_reg(rpc_pkg::REG_QUAT_Y, {16'($urandom), y});
    write_reg(rpc_pkg::REG_QUAT_Z, {16'($urandom), z});
    write_reg(rpc_pkg::REG_QUAT_W, {16'($urandom), w});
    if ($urandom_range(0, 1) == 1) write_reg(REG_UNUSED, $urandom);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // sender paused until every composed pose has come out
  task automatic wait_drained();
    do @(posedge clk); while (pose_q.size() != 0 || in_valid || composed_q.size() != 0);
  endtask

  // ---------------------------------------------------------------- input driver

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pose_q.size() > 0) begin
        cur_pose = pose_q.pop_front();
        in_pos_x  <= cur_pose.px;
        in_pos_y  <= cur_pose.py;
        in_pos_z  <= cur_pose.pz;
        in_quat_x <= cur_pose.qx;
        in_quat_y <= cur_pose.qy;
        in_quat_z <= cur_pose.qz;
        in_quat_w <= cur_pose.qw;
        in_valid  <= 1'b1;
        if (burst_left > 0) burst_left--;
        // end of burst: pick the next burst and the gap before it
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 3);
            8:          gap_left = $urandom_range(4, 10);
            default:    gap_left = $urandom_range(11, 24);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- output stall pattern

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    stall_cyc++;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 1);
      2:       out_ready <= ((stall_cyc % 5) != 4);
      default: out_ready <= ($urandom_range(0, 9) < 2);
    endcase
  end

  // ---------------------------------------------------------------- monitor and checker

  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        composed_q.push_back(compose_pose(cur_pose));
        poses_sent++;
      end
      if (out_valid && out_ready) begin
        got.px = out_pos_x;  got.py = out_pos_y;  got.pz = out_pos_z;
        got.qx = out_quat_x; got.qy = out_quat_y; got.qz = out_quat_z;
        got.qw = out_quat_w;
        results_seen++;
        if (composed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: %s", pose_str(got));
        end else begin
          want = composed_q.pop_front();
          if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz ||
              got.qx !== want.qx || got.qy !== want.qy || got.qz !== want.qz ||
              got.qw !== want.qw) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d", results_seen);
              $display("  expected %s", pose_str(want));
              $display("  actual   %s", pose_str(got));
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = rpc_pkg::REG_POS_X;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_pos_x   = '0; in_pos_y  = '0; in_pos_z  = '0;
    in_quat_x  = '0; in_quat_y = '0; in_quat_z = '0; in_quat_w = '0;
    out_ready  = 1'b0;
    in_taken   = 1'b0;
    head_px = '0; head_py = '0; head_pz = '0;
    head_qx = '0; head_qy = '0; head_qz = '0; head_qw = rpc_pkg::QUAT_ONE;
    burst_left = $urandom_range(1, 48);
    gap_left   = 0;
    stall_mode = 0;
    stall_left = 0;
    stall_cyc  = 0;
    poses_sent = 0; results_seen = 0; mismatches = 0; cfg_writes = 0; settings = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity head pose straight out of reset
    add_pose(0, 0, 0, 0, 0, 0, 0);
    add_pose(P_MAX, P_MAX, P_MAX, 0, 0, 0, Q_ONE);
    add_pose(P_MIN, P_MIN, P_MIN, Q_MONE, 0, 0, 0);
    add_pose(P_MAX, P_MIN, -1, 0, Q_ONE, 0, 0);
    add_pose(1, -1, 0, 0, 0, Q_MONE, 0);
    // non-unit quaternion, passed through unchanged by the identity head
    add_pose(256, 512, -768, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    add_pose(P_MIN, P_MIN, P_MIN, Q_MONE, Q_MONE, Q_MONE, Q_MONE);
    // components beyond plus or minus one
    add_pose(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f,
             -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    add_pose(1000, -2000, 3000, 16'sd11585, 0, 0, 16'sd11585);
    wait_drained();

    // largest offset and a non-unit head quaternion
    load_head(P_MAX, P_MAX, P_MAX, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    add_pose(P_MAX, P_MAX, P_MAX, 0, 0, 0, Q_ONE);
    add_pose(P_MIN, P_MIN, P_MIN, 0, 0, 0, Q_ONE);
    add_pose(0, 0, 0, 0, 0, 0, 0);
    add_pose(32'shaaaaaaaa, 32'sh55555555, -1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    wait_drained();

    // smallest offset, negated identity
    load_head(P_MIN, P_MIN, P_MIN, 0, 0, 0, Q_MONE);
    add_pose(P_MIN, P_MIN, P_MIN, 0, 0, 0, Q_ONE);
    add_pose(P_MAX, P_MAX, P_MAX, Q_MONE, Q_MONE, Q_MONE, Q_MONE);
    add_pose(0, 0, 0, Q_ONE, 0, 0, 0);
    wait_drained();

    // quarter turn about z, no offset
    load_head(0, 0, 0, 0, 0, 16'sd11585, 16'sd11585);
    add_pose(P_MAX, P_MIN, P_MAX, 0, 0, 0, Q_ONE);
    add_pose(25600, -12800, 6400, 16'sd11585, 0, 0, 16'sd11585);

    // random head poses, each with a run of random object poses
    for (int ph = 0; ph < 12; ph++) begin
      wait_drained();
      if ($urandom_range(0, 3) == 0) begin
        load_head($urandom_range(0, 1) ? P_MAX : P_MIN,
                  $urandom_range(0, 1) ? P_MAX : P_MIN,
                  $urandom_range(0, 1) ? P_MAX : P_MIN,
                  $urandom_range(0, 1) ? Q_ONE : Q_MONE,
                  $urandom_range(0, 1) ? Q_ONE : Q_MONE,
                  $urandom_range(0, 1) ? Q_ONE : Q_MONE,
                  $urandom_range(0, 1) ? Q_ONE : Q_MONE);
      end else begin
        load_head(rand_pos(), rand_pos(), rand_pos(),
                  rand_qc(), rand_qc(), rand_qc(), rand_qc());
      end
      repeat ($urandom_range(40, 80)) begin
        add_pose(rand_pos(), rand_pos(), rand_pos(),
                 rand_qc(), rand_qc(), rand_qc(), rand_qc());
      end
    end

    wait_drained();
    repeat (rpc_pkg::PIPE_STAGES * 4) @(posedge clk);

    $display("covered %0d poses under %0d head poses set by %0d register writes",
             poses_sent, settings, cfg_writes);
    $display("checked %0d composed poses, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && composed_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
